[sv/frs_pkg.sv]
// frs_pkg: widths, reset values, register indexes and result word types
// for the free run scanner; used by every module of the block
package frs_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int CNT_BITS   = 17;
    localparam int BYTE_BITS  = 8;
    localparam int CFG_BITS   = 17;
    localparam int RPT_BITS   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QLVL_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_BITS-1:0] RANGE_START_RST = ADDR_BITS'(512);
    localparam logic [ADDR_BITS-1:0] RANGE_END_RST   = ADDR_BITS'(15871);
    localparam logic [CNT_BITS-1:0]  MIN_RUN_RST     = CNT_BITS'(16);
    localparam logic [RPT_BITS-1:0]  MAX_REPORTS_RST = RPT_BITS'(8);

    localparam logic [BYTE_BITS-1:0] BYTE_ZERO = 8'h00;
    localparam logic [BYTE_BITS-1:0] BYTE_ONES = 8'hFF;
    localparam logic [CNT_BITS-1:0]  CNT_MAX   = {CNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        CFG_RANGE_START = 2'd0,
        CFG_RANGE_END   = 2'd1,
        CFG_MIN_RUN     = 2'd2,
        CFG_MAX_REPORTS = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        KIND_RUN     = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                report_kind;
        logic [ADDR_BITS-1:0] run_first;
        logic [ADDR_BITS-1:0] run_final;
        logic [CNT_BITS-1:0]  run_length;
        logic [CNT_BITS-1:0]  zero_bytes;
        logic [CNT_BITS-1:0]  ones_bytes;
        logic [CNT_BITS-1:0]  used_bytes;
        logic [CNT_BITS-1:0]  free_bytes;
        logic [CNT_BITS-1:0]  range_bytes;
        logic                 final_of_item;
    } result_t;

    // up to two result words produced by one byte
    typedef struct packed {
        logic [1:0] count;
        result_t    word0;
        result_t    word1;
    } push_t;

endpackage

[sv/frs_in_stage.sv]
// frs_in_stage: input register holding one byte until the core takes it
// depends on frs_pkg
module frs_in_stage
    import frs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_BITS-1:0] data_byte,
    input  logic                 take,
    output logic                 busy,
    output logic [BYTE_BITS-1:0] held_byte
);

    logic                 busy_reg;
    logic                 busy_next;
    logic [BYTE_BITS-1:0] byte_reg;
    logic                 accept;

    assign in_stall = busy_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (take)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
        end
    end

    assign busy      = busy_reg;
    assign held_byte = byte_reg;

endmodule

[sv/frs_core.sv]
// frs_core: configuration registers, scan state and per-byte classification
// builds the run report and summary words; depends on frs_pkg
module frs_core
    import frs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_BITS-1:0]  cfg_data,
    input  logic                 take,
    input  logic [BYTE_BITS-1:0] held_byte,
    output push_t                push
);

    logic [ADDR_BITS-1:0] range_start_reg;
    logic [ADDR_BITS-1:0] range_end_reg;
    logic [CNT_BITS-1:0]  min_run_reg;
    logic [RPT_BITS-1:0]  max_reports_reg;

    logic [ADDR_BITS-1:0] next_address_reg;
    logic [CNT_BITS-1:0]  zero_count_reg;
    logic [CNT_BITS-1:0]  ones_count_reg;
    logic [CNT_BITS-1:0]  used_count_reg;
    logic                 in_run_reg;
    logic [ADDR_BITS-1:0] run_begin_reg;
    logic [RPT_BITS-1:0]  reports_made_reg;

    logic [ADDR_BITS-1:0] next_address_next;
    logic [CNT_BITS-1:0]  zero_count_next;
    logic [CNT_BITS-1:0]  ones_count_next;
    logic [CNT_BITS-1:0]  used_count_next;
    logic                 in_run_next;
    logic [ADDR_BITS-1:0] run_begin_next;
    logic [RPT_BITS-1:0]  reports_made_next;

    logic                 is_zero;
    logic                 is_ones;
    logic                 is_free;
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] end_addr;
    logic                 at_end;
    logic [CNT_BITS-1:0]  zero_upd;
    logic [CNT_BITS-1:0]  ones_upd;
    logic [CNT_BITS-1:0]  used_upd;
    logic [ADDR_BITS-1:0] begin_upd;
    logic                 close_used;
    logic                 close_end;
    logic [CNT_BITS-1:0]  len_used;
    logic [CNT_BITS-1:0]  len_end;
    logic                 room_left;
    logic                 rep_used;
    logic                 rep_end;
    logic                 rep_any;
    logic [CNT_BITS:0]    free_sum;
    result_t              run_word;
    result_t              sum_word;
    logic                 scan_fresh;

    function automatic logic [CNT_BITS-1:0] bump(input logic [CNT_BITS-1:0] c);
        bump = (c == CNT_MAX) ? CNT_MAX : c + CNT_BITS'(1);
    endfunction

    assign is_zero  = (held_byte == BYTE_ZERO);
    assign is_ones  = (held_byte == BYTE_ONES);
    assign is_free  = is_zero || is_ones;
    assign addr     = next_address_reg;
    assign end_addr = (range_end_reg < range_start_reg) ? range_start_reg : range_end_reg;
    assign at_end   = (addr >= end_addr);

    assign zero_upd  = is_zero ? bump(zero_count_reg) : zero_count_reg;
    assign ones_upd  = is_ones ? bump(ones_count_reg) : ones_count_reg;
    assign used_upd  = is_free ? used_count_reg : bump(used_count_reg);
    assign begin_upd = (is_free && !in_run_reg) ? addr : run_begin_reg;

    // a used byte closes the run at the address before it
    assign close_used = !is_free && in_run_reg && (addr > run_begin_reg);
    assign close_end  = at_end && is_free;
    assign len_used   = {1'b0, addr} - {1'b0, run_begin_reg};
    assign len_end    = {1'b0, addr} - {1'b0, begin_upd} + CNT_BITS'(1);
    assign room_left  = (reports_made_reg < max_reports_reg);
    assign rep_used   = close_used && (len_used >= min_run_reg) && room_left;
    assign rep_end    = close_end && (len_end >= min_run_reg) && room_left;
    assign rep_any    = rep_used || rep_end;

    assign free_sum = {1'b0, zero_upd} + {1'b0, ones_upd};

    always_comb
    begin
        run_word               = '0;
        run_word.report_kind   = KIND_RUN;
        run_word.run_first     = close_used ? run_begin_reg : begin_upd;
        run_word.run_final     = close_used ? addr - ADDR_BITS'(1) : addr;
        run_word.run_length    = close_used ? len_used : len_end;
        run_word.final_of_item = !at_end;

        sum_word               = '0;
        sum_word.report_kind   = KIND_SUMMARY;
        sum_word.zero_bytes    = zero_upd;
        sum_word.ones_bytes    = ones_upd;
        sum_word.used_bytes    = used_upd;
        sum_word.free_bytes    = free_sum[CNT_BITS] ? CNT_MAX : free_sum[CNT_BITS-1:0];
        sum_word.range_bytes   = {1'b0, end_addr} - {1'b0, range_start_reg} + CNT_BITS'(1);
        sum_word.final_of_item = 1'b1;

        push.count = take ? ({1'b0, rep_any} + {1'b0, at_end}) : 2'd0;
        push.word0 = rep_any ? run_word : sum_word;
        push.word1 = sum_word;
    end

    assign scan_fresh = (zero_count_reg == '0) && (ones_count_reg == '0)
                        && (used_count_reg == '0);

    always_comb
    begin
        next_address_next = next_address_reg;
        zero_count_next   = zero_count_reg;
        ones_count_next   = ones_count_reg;
        used_count_next   = used_count_reg;
        in_run_next       = in_run_reg;
        run_begin_next    = run_begin_reg;
        reports_made_next = reports_made_reg;
        if (take)
        begin
            if (at_end)
            begin
                next_address_next = range_start_reg;
                zero_count_next   = '0;
                ones_count_next   = '0;
                used_count_next   = '0;
                in_run_next       = 1'b0;
                run_begin_next    = '0;
                reports_made_next = '0;
            end
            else
            begin
                next_address_next = addr + ADDR_BITS'(1);
                zero_count_next   = zero_upd;
                ones_count_next   = ones_upd;
                used_count_next   = used_upd;
                in_run_next       = is_free;
                run_begin_next    = begin_upd;
                reports_made_next = reports_made_reg + RPT_BITS'(rep_any);
            end
        end
        // a new start moves the address only before the first byte of a scan
        if (cfg_write && (cfg_idx_t'(cfg_index) == CFG_RANGE_START) && scan_fresh)
        begin
            next_address_next = cfg_data[ADDR_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= RANGE_START_RST;
            range_end_reg   <= RANGE_END_RST;
            min_run_reg     <= MIN_RUN_RST;
            max_reports_reg <= MAX_REPORTS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RANGE_START: range_start_reg <= cfg_data[ADDR_BITS-1:0];
                CFG_RANGE_END:   range_end_reg   <= cfg_data[ADDR_BITS-1:0];
                CFG_MIN_RUN:     min_run_reg     <= cfg_data[CNT_BITS-1:0];
                CFG_MAX_REPORTS: max_reports_reg <= cfg_data[RPT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_address_reg <= RANGE_START_RST;
            zero_count_reg   <= '0;
            ones_count_reg   <= '0;
            used_count_reg   <= '0;
            in_run_reg       <= 1'b0;
            run_begin_reg    <= '0;
            reports_made_reg <= '0;
        end
        else
        begin
            next_address_reg <= next_address_next;
            zero_count_reg   <= zero_count_next;
            ones_count_reg   <= ones_count_next;
            used_count_reg   <= used_count_next;
            in_run_reg       <= in_run_next;
            run_begin_reg    <= run_begin_next;
            reports_made_reg <= reports_made_next;
        end
    end

endmodule

[sv/frs_out_queue.sv]
// frs_out_queue: four-word result queue, takes up to two words a cycle
// and hands one word a cycle to the output while out_stall is low; depends on frs_pkg
module frs_out_queue
    import frs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  push_t                push,
    output logic                 out_valid,
    input  logic                 out_stall,
    output result_t              head,
    output logic [QLVL_BITS-1:0] level
);

    result_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_next;
    logic [QLVL_BITS-1:0]  level_reg;
    logic [QLVL_BITS-1:0]  level_next;
    logic                  pop;

    assign out_valid = (level_reg != '0);
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_BITS'(pop);
        level_next  = level_reg + QLVL_BITS'(push.count) - QLVL_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.word0;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[wr_ptr_reg + QPTR_BITS'(1)] <= push.word1;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign level = level_reg;

endmodule

[sv/free_run_scanner.sv]
// free_run_scanner: top level, joins input register, scan core and result queue
// depends on frs_pkg, frs_in_stage, frs_core, frs_out_queue
//
// One byte of the address range is taken per cycle, back to back while the
// result queue has room, in address order starting at range_start. A byte is
// held in the input register, is classified and folded into the scan state as
// the core takes it, and its results are registered into the result queue,
// whose head drives the outputs. Most bytes give no result; a byte that closes a
// reportable run gives a run word, the last byte of the range gives the summary
// word, and a byte may give both, delivered one after the other with
// final_of_item on the last. Results wait in a four-word queue; the input
// register stalls while the queue holds more than two words, which only output
// stall or a run of two-word bytes can cause. Configuration writes belong while
// the block is idle; a new range_start applies at once only before the first
// byte of a scan.
module free_run_scanner
    import frs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_BITS-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_BITS-1:0] data_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 report_kind,
    output logic [ADDR_BITS-1:0] run_first,
    output logic [ADDR_BITS-1:0] run_final,
    output logic [CNT_BITS-1:0]  run_length,
    output logic [CNT_BITS-1:0]  zero_bytes,
    output logic [CNT_BITS-1:0]  ones_bytes,
    output logic [CNT_BITS-1:0]  used_bytes,
    output logic [CNT_BITS-1:0]  free_bytes,
    output logic [CNT_BITS-1:0]  range_bytes,
    output logic                 final_of_item
);

    logic                 busy;
    logic                 take;
    logic [BYTE_BITS-1:0] held_byte;
    push_t                push;
    result_t              head;
    logic [QLVL_BITS-1:0] level;

    // the core may only run when the queue has room for two words
    assign take = busy && (level <= QLVL_BITS'(QUEUE_DEPTH - 2));

    frs_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .take      (take),
        .busy      (busy),
        .held_byte (held_byte)
    );

    frs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .held_byte (held_byte),
        .push      (push)
    );

    frs_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head),
        .level     (level)
    );

    assign report_kind   = head.report_kind;
    assign run_first     = head.run_first;
    assign run_final     = head.run_final;
    assign run_length    = head.run_length;
    assign zero_bytes    = head.zero_bytes;
    assign ones_bytes    = head.ones_bytes;
    assign used_bytes    = head.used_bytes;
    assign free_bytes    = head.free_bytes;
    assign range_bytes   = head.range_bytes;
    assign final_of_item = head.final_of_item;

`ifndef SYNTHESIS
    a_push_max_two: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd3)
        else $error("more than two words from one byte");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= QLVL_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> take)
        else $error("words pushed without a byte taken");

    a_summary_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && report_kind) |-> final_of_item)
        else $error("summary word not marked last of its byte");
`endif

endmodule

[bench/free_run_scanner_tb.sv]
`timescale 1ns / 1ps
// free_run_scanner_tb: self-checking bench for free_run_scanner; a byte-level scan
// predictor feeds a queue of due result words that a monitor checks field by field
// depends on frs_pkg and free_run_scanner
module free_run_scanner_tb
    import frs_pkg::*;
();

    localparam int CYCLE_LIMIT  = 600000;
    localparam int TOTAL_BYTES  = 1280;
    localparam int CALM_BYTES   = 1130;
    localparam int DRAIN_CYCLES = 6;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [1:0]           cfg_index = CFG_RANGE_START;
    logic [CFG_BITS-1:0]  cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_BITS-1:0] data_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 report_kind;
    logic [ADDR_BITS-1:0] run_first;
    logic [ADDR_BITS-1:0] run_final;
    logic [CNT_BITS-1:0]  run_length;
    logic [CNT_BITS-1:0]  zero_bytes;
    logic [CNT_BITS-1:0]  ones_bytes;
    logic [CNT_BITS-1:0]  used_bytes;
    logic [CNT_BITS-1:0]  free_bytes;
    logic [CNT_BITS-1:0]  range_bytes;
    logic                 final_of_item;

    free_run_scanner DUT (.*);

    // predictor copy of the registers and of the scan state
    logic [ADDR_BITS-1:0] cfg_first_addr;
    logic [ADDR_BITS-1:0] cfg_last_addr;
    logic [CNT_BITS-1:0]  cfg_min_run;
    logic [RPT_BITS-1:0]  cfg_max_runs;
    logic [ADDR_BITS-1:0] scan_addr;
    logic [CNT_BITS-1:0]  n_zero;
    logic [CNT_BITS-1:0]  n_ones;
    logic [CNT_BITS-1:0]  n_used;
    logic                 run_open;
    logic [ADDR_BITS-1:0] run_origin;
    logic [RPT_BITS-1:0]  runs_told;

    logic [BYTE_BITS-1:0] bytes_to_send[$];
    result_t              due_words[$];
    result_t              batch[2];
    int                   batch_n;
    result_t              seen_word;
    result_t              want_word;

    logic byte_taken = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   idle_pct = 0;
    int   cycles = 0;
    int   errors = 0;
    int   bytes_fed = 0;
    int   runs_seen = 0;
    int   summaries_seen = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [CNT_BITS-1:0] bump(input logic [CNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_BITS'(1);
    endfunction

    // a range end below the start collapses the range onto the start
    function automatic logic [ADDR_BITS-1:0] scan_last();
        return (cfg_last_addr < cfg_first_addr) ? cfg_first_addr : cfg_last_addr;
    endfunction

    function automatic int bytes_left();
        if (scan_addr >= scan_last())
            return 1;
        return int'(scan_last()) - int'(scan_addr) + 1;
    endfunction

    task restart_scan();
        scan_addr  = cfg_first_addr;
        n_zero     = '0;
        n_ones     = '0;
        n_used     = '0;
        run_open   = 1'b0;
        run_origin = '0;
        runs_told  = '0;
    endtask

    task offer_run(input logic [ADDR_BITS-1:0] first, input logic [ADDR_BITS-1:0] last);
        logic [31:0] len;
        len = {16'd0, last} - {16'd0, first} + 32'd1;
        if (len >= {15'd0, cfg_min_run} && runs_told < cfg_max_runs)
        begin
            batch[batch_n] = '0;
            batch[batch_n].report_kind = KIND_RUN;
            batch[batch_n].run_first = first;
            batch[batch_n].run_final = last;
            batch[batch_n].run_length = len[CNT_BITS-1:0];
            batch_n++;
            runs_told++;
        end
    endtask

    task scan_byte(input logic [BYTE_BITS-1:0] b);
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] last;
        logic [CNT_BITS:0]    free_sum;
        addr = scan_addr;
        last = scan_last();
        batch_n = 0;
        if (b == BYTE_ZERO || b == BYTE_ONES)
        begin
            if (b == BYTE_ZERO)
                n_zero = bump(n_zero);
            else
                n_ones = bump(n_ones);
            if (!run_open)
            begin
                run_open = 1'b1;
                run_origin = addr;
            end
        end
        else
        begin
            n_used = bump(n_used);
            if (run_open && addr > run_origin)
                offer_run(run_origin, addr - ADDR_BITS'(1));
            run_open = 1'b0;
        end
        if (addr >= last)
        begin
            // a free last byte closes its run together with the range
            if (run_open)
                offer_run(run_origin, addr);
            free_sum = {1'b0, n_zero} + {1'b0, n_ones};
            batch[batch_n] = '0;
            batch[batch_n].report_kind = KIND_SUMMARY;
            batch[batch_n].zero_bytes = n_zero;
            batch[batch_n].ones_bytes = n_ones;
            batch[batch_n].used_bytes = n_used;
            batch[batch_n].free_bytes = (free_sum > {1'b0, CNT_MAX}) ? CNT_MAX
                                                                      : free_sum[CNT_BITS-1:0];
            batch[batch_n].range_bytes = {1'b0, last} - {1'b0, cfg_first_addr}
                                         + CNT_BITS'(1);
            batch_n++;
            restart_scan();
        end
        else
        begin
            scan_addr = addr + ADDR_BITS'(1);
        end
        if (batch_n > 0)
            batch[batch_n-1].final_of_item = 1'b1;
        for (int i = 0; i < batch_n; i++)
            due_words.push_back(batch[i]);
    endtask

    task write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_RANGE_START:
            begin
                cfg_first_addr = value[ADDR_BITS-1:0];
                // a new start only moves the address before the first byte of a scan
                if (n_zero == '0 && n_ones == '0 && n_used == '0)
                    scan_addr = cfg_first_addr;
            end
            CFG_RANGE_END:   cfg_last_addr = value[ADDR_BITS-1:0];
            CFG_MIN_RUN:     cfg_min_run = value;
            CFG_MAX_REPORTS: cfg_max_runs = value[RPT_BITS-1:0];
        endcase
    endtask

    task feed(input logic [BYTE_BITS-1:0] b, input int n);
        repeat (n) bytes_to_send.push_back(b);
        bytes_fed += n;
    endtask

    // free runs around min_run with used bytes between them, plus some noise
    task load_bytes(input int n);
        int seg;
        int pick;
        int cls;
        logic [BYTE_BITS-1:0] b;
        while (n > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                cls = $urandom_range(0, 2);
                if (pick < 3)
                    seg = $urandom_range(50, 300);
                else if (cfg_min_run <= 40)
                    seg = $urandom_range(1, cfg_min_run + 4);
                else
                    seg = $urandom_range(1, 40);
            end
            else if (pick < 90)
            begin
                cls = 3;
                seg = $urandom_range(1, 3);
            end
            else
            begin
                cls = 4;
                seg = 1;
            end
            if (seg > n)
                seg = n;
            for (int k = 0; k < seg; k++)
            begin
                case (cls)
                    0:       b = BYTE_ZERO;
                    1:       b = BYTE_ONES;
                    2:       b = $urandom_range(0, 1) ? BYTE_ZERO : BYTE_ONES;
                    3:       b = 8'($urandom_range(1, 254));
                    default: b = 8'($urandom_range(0, 255));
                endcase
                bytes_to_send.push_back(b);
            end
            bytes_fed += seg;
            n -= seg;
        end
    endtask

    // wait until the block has drained everything it was given
    task settle();
        while (bytes_to_send.size() != 0 || in_valid || due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // byte driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !byte_taken)
            begin
                // stalled byte stays put
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (bytes_to_send.size() != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                gap_left = $urandom_range(1, 17) - 1;
                in_valid <= 1'b0;
            end
            else if (bytes_to_send.size() != 0)
            begin
                in_valid  <= 1'b1;
                data_byte <= bytes_to_send.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task complain(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= 40)
            $display("mismatch in %s: got %0h, expected %0h at cycle %0d", what, got, want, cycles);
    endtask

    // acceptance, prediction and result check
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d with %0d words still due", cycles, due_words.size());
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            byte_taken <= rst_n && in_valid && !in_stall;
            if (rst_n && in_valid && !in_stall)
                scan_byte(data_byte);
            if (rst_n && out_valid && !out_stall)
            begin
                seen_word = '{kind_t'(report_kind), run_first, run_final, run_length,
                              zero_bytes, ones_bytes, used_bytes, free_bytes, range_bytes,
                              final_of_item};
                if (due_words.size() == 0)
                begin
                    complain("unexpected word, kind", 32'(seen_word.report_kind), 0);
                end
                else
                begin
                    want_word = due_words.pop_front();
                    if (want_word.report_kind == KIND_SUMMARY)
                        summaries_seen++;
                    else
                        runs_seen++;
                    if (seen_word.report_kind !== want_word.report_kind)
                        complain("report_kind", 32'(seen_word.report_kind),
                                 32'(want_word.report_kind));
                    if (seen_word.run_first !== want_word.run_first)
                        complain("run_first", 32'(seen_word.run_first),
                                 32'(want_word.run_first));
                    if (seen_word.run_final !== want_word.run_final)
                        complain("run_final", 32'(seen_word.run_final),
                                 32'(want_word.run_final));
                    if (seen_word.run_length !== want_word.run_length)
                        complain("run_length", 32'(seen_word.run_length),
                                 32'(want_word.run_length));
                    if (seen_word.zero_bytes !== want_word.zero_bytes)
                        complain("zero_bytes", 32'(seen_word.zero_bytes),
                                 32'(want_word.zero_bytes));
                    if (seen_word.ones_bytes !== want_word.ones_bytes)
                        complain("ones_bytes", 32'(seen_word.ones_bytes),
                                 32'(want_word.ones_bytes));
                    if (seen_word.used_bytes !== want_word.used_bytes)
                        complain("used_bytes", 32'(seen_word.used_bytes),
                                 32'(want_word.used_bytes));
                    if (seen_word.free_bytes !== want_word.free_bytes)
                        complain("free_bytes", 32'(seen_word.free_bytes),
                                 32'(want_word.free_bytes));
                    if (seen_word.range_bytes !== want_word.range_bytes)
                        complain("range_bytes", 32'(seen_word.range_bytes),
                                 32'(want_word.range_bytes));
                    if (seen_word.final_of_item !== want_word.final_of_item)
                        complain("final_of_item", 32'(seen_word.final_of_item),
                                 32'(want_word.final_of_item));
                end
            end
        end
    end

    initial
    begin
        int pick;
        int span;
        int cut;
        logic [ADDR_BITS-1:0] first;
        logic [ADDR_BITS-1:0] last;

        cfg_first_addr = RANGE_START_RST;
        cfg_last_addr  = RANGE_END_RST;
        cfg_min_run    = MIN_RUN_RST;
        cfg_max_runs   = MAX_REPORTS_RST;
        restart_scan();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset start, min_run and max_reports; a run of exactly min_run closed by
        // a used byte, then a one-byte run too short to report at the range end
        write_reg(CFG_RANGE_END, 17'd529);
        feed(BYTE_ZERO, 8);
        feed(BYTE_ONES, 8);
        feed(8'h5A, 1);
        feed(BYTE_ONES, 1);
        settle();

        // one-byte range at the top address with the end below the start
        idle_pct = 20;
        write_reg(CFG_RANGE_START, 17'hFFFF);
        write_reg(CFG_RANGE_END, 17'd0);
        write_reg(CFG_MIN_RUN, 17'd1);
        feed(BYTE_ONES, 1);
        settle();

        // min_run of zero, then the end pulled below the current address mid-scan
        write_reg(CFG_MIN_RUN, 17'd0);
        write_reg(CFG_MAX_REPORTS, 17'd255);
        write_reg(CFG_RANGE_START, 17'd100);
        write_reg(CFG_RANGE_END, 17'd200);
        feed(BYTE_ZERO, 1);
        feed(8'h81, 1);
        feed(8'h7E, 1);
        settle();
        write_reg(CFG_RANGE_END, 17'd50);
        feed(BYTE_ZERO, 1);
        settle();

        // start moved to zero mid-scan gives the full 64k range size; the used last
        // byte closes the run before the summary
        write_reg(CFG_RANGE_START, 17'hFFFD);
        write_reg(CFG_RANGE_END, 17'hFFFF);
        write_reg(CFG_MIN_RUN, 17'd2);
        feed(BYTE_ZERO, 1);
        settle();
        write_reg(CFG_RANGE_START, 17'd0);
        feed(BYTE_ONES, 1);
        feed(8'h80, 1);
        settle();

        while (bytes_fed < TOTAL_BYTES)
        begin
            pick = $urandom_range(0, 4);
            idle_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 15 :
                       (pick == 3) ? 30 : 60;
            if (bytes_fed >= CALM_BYTES)
                idle_pct = 0;

            pick = $urandom_range(0, 99);
            span = (pick < 80) ? $urandom_range(1, 48) :
                   (pick < 95) ? $urandom_range(49, 160) : $urandom_range(161, 420);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                first = '0;
            else if (pick < 16)
                first = 16'hFFFF - 16'($urandom_range(0, 40));
            else
                first = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) == 0 && first != 0)
                last = 16'($urandom_range(0, first - 1));
            else if (int'(first) + span - 1 > 65535)
                last = 16'hFFFF;
            else
                last = 16'(int'(first) + span - 1);
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_RANGE_START, {1'b0, first});
                write_reg(CFG_RANGE_END, {1'b0, last});
            end
            else
            begin
                write_reg(CFG_RANGE_END, {1'b0, last});
                write_reg(CFG_RANGE_START, {1'b0, first});
            end

            if ($urandom_range(0, 99) < 60)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    write_reg(CFG_MIN_RUN, 17'd0);
                else if (pick < 15)
                    write_reg(CFG_MIN_RUN, 17'h10000);
                else if (pick < 20)
                    write_reg(CFG_MIN_RUN, 17'($urandom_range(0, 131071)));
                else
                    write_reg(CFG_MIN_RUN, 17'($urandom_range(1, 10)));
            end
            if ($urandom_range(0, 99) < 50)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    write_reg(CFG_MAX_REPORTS, 17'd0);
                else if (pick < 25)
                    write_reg(CFG_MAX_REPORTS, 17'd255);
                else if (pick < 35)
                    write_reg(CFG_MAX_REPORTS, 17'($urandom_range(0, 255)));
                else
                    write_reg(CFG_MAX_REPORTS, 17'($urandom_range(1, 4)));
            end

            // part of the scan, a register change while idle, then the rest
            if ($urandom_range(0, 3) == 0 && bytes_left() > 1)
            begin
                load_bytes($urandom_range(1, bytes_left() - 1));
                settle();
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    write_reg(CFG_RANGE_END, 17'($urandom_range(0, int'(scan_addr) - 1)));
                end
                else if (pick < 60)
                begin
                    cut = int'(scan_addr) + $urandom_range(0, 40);
                    write_reg(CFG_RANGE_END, 17'((cut > 65535) ? 65535 : cut));
                end
                else if (pick < 75)
                begin
                    write_reg(CFG_RANGE_START, 17'($urandom_range(0, int'(scan_addr))));
                end
                else if (pick < 88)
                begin
                    write_reg(CFG_MIN_RUN, 17'($urandom_range(0, 20)));
                end
                else
                begin
                    write_reg(CFG_MAX_REPORTS, 17'($urandom_range(0, 5)));
                end
            end
            load_bytes(bytes_left());
            settle();
        end

        $display("scanned %0d bytes in %0d scans, registers changed between and within scans",
                 bytes_fed, summaries_seen);
        $display("compared %0d run reports and %0d summaries, %0d mismatches",
                 runs_seen, summaries_seen, errors);
        if (errors == 0 && due_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
